[rtl/core/btip_pkg.sv]
// shared types and constants of the breakpoint table interpolator
package btip_pkg;

    // width of the breakpoint count register, also bounds the segment index
    localparam int CNT_W = 5;

    localparam logic CFG_KIND  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [1:0] KIND_NEAREST = 2'd0;
    localparam logic [1:0] KIND_CLAMP   = 2'd1;

    localparam logic MODE_LOAD = 1'b0;

    // query word travelling along the row of breakpoint cells
    typedef struct packed {
        logic               phase;  // 0 counts the segment, 1 picks its ends
        logic signed [31:0] xv;
        logic [CNT_W-1:0]   s;
        logic [CNT_W-1:0]   n;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] xa;
        logic signed [31:0] ya;
        logic signed [31:0] xb;
        logic signed [31:0] yb;
    } t_token;

endpackage

[rtl/core/breakpoint_table_interpolator_unit.sv]
// top level of the breakpoint table interpolator
//
// input channel: i_in_valid / o_in_stall carry one word per item. a load word
// (i_mode low) writes x and y into slot i_point_index, slots at or above
// MAX_POINTS are ignored. an evaluate word returns y at i_x_value.
// output channel: o_out_valid / i_out_stall, one result word per input word;
// load words return all zero fields.
// config port: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 interp kind, 1 point count). the user must write it only while no item
// is in flight; the block itself does not enforce this.
// a load word goes straight to the done state. an evaluate word walks the row
// of MAX_POINTS cells twice, first counting the segment and then picking its
// ends; linear interpolation inside a segment adds a multiply in two halves
// and a 66-bit divider that makes one quotient bit per cycle. one item is in
// work at a time: no input word is taken until the last result has moved on.
// the output register holds a finished word while the receiver stalls, and
// the next input word is accepted meanwhile; its result waits until the
// register is free.
// reset clears control state and sets interp kind 0, point count 2; the
// breakpoint slots hold nothing defined until written.
module breakpoint_table_interpolator_unit
    import btip_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [3:0]         i_point_index,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_below_range,
    output logic               o_above_range,
    output logic               o_saturated
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [8:0] MAX_W = 9'(MAX_POINTS);

    logic [2:0]         r_state;
    logic [1:0]         r_kind;
    logic [CNT_W-1:0]   r_count;
    logic               r_inj_vld;
    t_token             r_inj_tok;
    t_token             r_tok;
    logic signed [31:0] r_res;
    logic               r_below;
    logic               r_above;
    logic               r_sat;
    logic               r_start;
    logic               r_out_vld;
    logic signed [31:0] r_o_res;
    logic               r_o_below;
    logic               r_o_above;
    logic               r_o_sat;

    logic               w_accept;
    logic               w_load;
    logic [CNT_W-1:0]   w_n;
    logic               w_vld [0:MAX_POINTS];
    t_token             w_tok [0:MAX_POINTS];
    logic               w_below;
    logic               w_above;
    logic signed [32:0] w_da;
    logic signed [32:0] w_db;
    logic [32:0]        w_ma;
    logic [32:0]        w_mb;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic               w_out_free;
    logic               w_lerp_done;
    logic signed [31:0] w_lerp_res;
    logic               w_lerp_sat;

    assign o_in_stall = r_state != S_IDLE;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = w_accept && i_mode == MODE_LOAD;
    assign w_out_free = !r_out_vld || !i_out_stall;

    // point count limited to 2..MAX_POINTS
    always_comb begin
        if (r_count < CNT_W'(2)) begin
            w_n = CNT_W'(2);
        end else if ({{(9-CNT_W){1'b0}}, r_count} > MAX_W) begin
            w_n = MAX_W[CNT_W-1:0];
        end else begin
            w_n = r_count;
        end
    end

    // row of breakpoint cells, the query word enters at cell 0
    assign w_vld[0] = r_inj_vld;
    assign w_tok[0] = r_inj_tok;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        btip_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_load),
            .i_wr_index (i_point_index),
            .i_wr_x     (i_x_value),
            .i_wr_y     (i_y_value),
            .i_vld      (w_vld[g]),
            .i_tok      (w_tok[g]),
            .o_vld      (w_vld[g+1]),
            .o_tok      (w_tok[g+1])
        );
    end

    // segment arithmetic on the captured word
    assign w_below = r_tok.xv < r_tok.x0;
    assign w_above = r_tok.xv > r_tok.xl;
    assign w_da    = 33'(r_tok.xv) - 33'(r_tok.xa);
    assign w_db    = 33'(r_tok.xv) - 33'(r_tok.xb);
    assign w_ma    = w_da[32] ? 33'(-w_da) : 33'(w_da);
    assign w_mb    = w_db[32] ? 33'(-w_db) : 33'(w_db);
    assign w_dx    = 33'(r_tok.xb) - 33'(r_tok.xa);
    assign w_dy    = 33'(r_tok.yb) - 33'(r_tok.ya);

    btip_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_y0    (r_tok.ya),
        .i_dy    (w_dy),
        .i_t     (w_da),
        .i_dx    (w_dx),
        .o_done  (w_lerp_done),
        .o_res   (w_lerp_res),
        .o_sat   (w_lerp_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kind    <= KIND_NEAREST;
            r_count   <= CNT_W'(2);
            r_inj_vld <= 1'b0;
            r_start   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KIND:  r_kind  <= i_cfg_data[1:0];
                    CFG_COUNT: r_count <= i_cfg_data;
                    default: ;
                endcase
            end
            r_inj_vld <= 1'b0;
            r_start   <= 1'b0;
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_mode == MODE_LOAD) begin
                            r_res   <= '0;
                            r_below <= 1'b0;
                            r_above <= 1'b0;
                            r_sat   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_inj_tok       <= '0;
                            r_inj_tok.phase <= 1'b0;
                            r_inj_tok.xv    <= i_x_value;
                            r_inj_tok.n     <= w_n;
                            r_inj_vld       <= 1'b1;
                            r_state         <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_vld[MAX_POINTS]) begin
                        if (!w_tok[MAX_POINTS].phase) begin
                            // second pass picks the segment ends
                            r_inj_tok       <= w_tok[MAX_POINTS];
                            r_inj_tok.phase <= 1'b1;
                            r_inj_vld       <= 1'b1;
                        end else begin
                            r_tok   <= w_tok[MAX_POINTS];
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_below <= w_below;
                    r_above <= w_above;
                    r_sat   <= 1'b0;
                    r_state <= S_DONE;
                    if (r_kind == KIND_NEAREST) begin
                        // tie goes to the upper end
                        r_res <= (w_ma < w_mb) ? r_tok.ya : r_tok.yb;
                    end else if (r_kind == KIND_CLAMP && w_below) begin
                        r_res <= r_tok.y0;
                    end else if (r_kind == KIND_CLAMP && w_above) begin
                        r_res <= r_tok.yl;
                    end else if (w_dx <= 33'sd0) begin
                        // zero or negative width segment
                        r_res <= r_tok.ya;
                    end else begin
                        r_start <= 1'b1;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_lerp_done) begin
                        r_res   <= w_lerp_res;
                        r_sat   <= w_lerp_sat;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_res   <= r_res;
                        r_o_below <= r_below;
                        r_o_above <= r_above;
                        r_o_sat   <= r_sat;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_o_res;
    assign o_below_range  = r_o_below;
    assign o_above_range  = r_o_above;
    assign o_saturated    = r_o_sat;

endmodule

[rtl/core/btip_cell.sv]
// one breakpoint cell: stores an (x, y) pair and updates the passing query word
module btip_cell
    import btip_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [3:0]         i_wr_index,
    input  logic signed [31:0] i_wr_x,
    input  logic signed [31:0] i_wr_y,
    input  logic               i_vld,
    input  t_token             i_tok,
    output logic               o_vld,
    output t_token             o_tok
);

    localparam logic [8:0] IDX_W = 9'(IDX);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic               r_vld;
    t_token             r_tok;
    t_token             n_tok;
    logic [8:0]         w_n;
    logic [8:0]         w_s;

    assign w_n = {{(9-CNT_W){1'b0}}, i_tok.n};
    assign w_s = {{(9-CNT_W){1'b0}}, i_tok.s};

    always_ff @(posedge i_clk) begin
        if (i_wr_en && IDX_W == {5'b0, i_wr_index}) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.phase) begin
            // count inner breakpoints at or left of the query
            if (IDX_W != 9'd0 && (IDX_W + 9'd1) < w_n && r_x <= i_tok.xv) begin
                n_tok.s = i_tok.s + CNT_W'(1);
            end
            if (IDX_W == 9'd0) begin
                n_tok.x0 = r_x;
                n_tok.y0 = r_y;
            end
            if ((IDX_W + 9'd1) == w_n) begin
                n_tok.xl = r_x;
                n_tok.yl = r_y;
            end
        end else begin
            if (IDX_W == w_s) begin
                n_tok.xa = r_x;
                n_tok.ya = r_y;
            end
            if (IDX_W == (w_s + 9'd1)) begin
                n_tok.xb = r_x;
                n_tok.yb = r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

[rtl/core/btip_lerp.sv]
// multi-cycle rounded y0 + dy*t/dx with saturation to 32 bits
module btip_lerp
    import btip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_y0,
    input  logic signed [32:0] i_dy,
    input  logic signed [32:0] i_t,
    input  logic [32:0]        i_dx,
    output logic               o_done,
    output logic signed [31:0] o_res,
    output logic               o_sat
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_MUL0 = 3'd1;
    localparam logic [2:0] L_MUL1 = 3'd2;
    localparam logic [2:0] L_DIV  = 3'd3;
    localparam logic [2:0] L_RND  = 3'd4;
    localparam logic [2:0] L_FIN  = 3'd5;

    logic [2:0]         r_st;
    logic [6:0]         r_cnt;
    logic [32:0]        r_a;
    logic [32:0]        r_b;
    logic               r_neg;
    logic signed [31:0] r_y0;
    logic [32:0]        r_d;
    logic [65:0]        r_p;
    logic [32:0]        r_rem;
    logic [66:0]        r_q;
    logic               r_done;
    logic signed [31:0] r_res;
    logic               r_sat;

    logic [16:0]        w_mop;
    logic [49:0]        w_prod;
    logic [33:0]        w_rem_sh;
    logic               w_qbit;
    logic [33:0]        w_diff;
    logic               w_big;
    logic signed [38:0] w_q39;
    logic signed [38:0] w_y39;
    logic signed [38:0] w_sum;

    assign w_mop    = (r_st == L_MUL0) ? r_b[16:0] : {1'b0, r_b[32:17]};
    assign w_prod   = {17'b0, r_a} * {33'b0, w_mop};
    assign w_rem_sh = {r_rem, r_p[65]};
    assign w_qbit   = w_rem_sh >= {1'b0, r_d};
    assign w_diff   = w_rem_sh - {1'b0, r_d};
    assign w_big    = r_q > (67'd1 << 36);
    assign w_q39    = {2'b0, r_q[36:0]};
    assign w_y39    = 39'(r_y0);
    assign w_sum    = r_neg ? (w_y39 - w_q39) : (w_y39 + w_q39);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                L_IDLE: begin
                    if (i_start) begin
                        r_st <= L_MUL0;
                    end
                end
                L_MUL0: r_st <= L_MUL1;
                L_MUL1: r_st <= L_DIV;
                L_DIV: begin
                    if (r_cnt == 7'd0) begin
                        r_st <= L_RND;
                    end
                end
                L_RND: r_st <= L_FIN;
                L_FIN: begin
                    r_st   <= L_IDLE;
                    r_done <= 1'b1;
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            L_IDLE: begin
                r_a   <= i_dy[32] ? 33'(-i_dy) : 33'(i_dy);
                r_b   <= i_t[32] ? 33'(-i_t) : 33'(i_t);
                r_neg <= i_dy[32] != i_t[32];
                r_y0  <= i_y0;
                r_d   <= i_dx;
            end
            L_MUL0: begin
                r_p   <= {16'b0, w_prod};
                r_rem <= '0;
                r_cnt <= 7'd65;
            end
            L_MUL1: begin
                r_p <= r_p + {w_prod[48:0], 17'b0};
            end
            L_DIV: begin
                // one restoring step, quotient bits shift into the dividend
                r_rem <= w_qbit ? w_diff[32:0] : w_rem_sh[32:0];
                r_p   <= {r_p[64:0], w_qbit};
                r_cnt <= r_cnt - 7'd1;
            end
            L_RND: begin
                // round half away from zero on the magnitude
                r_q <= {1'b0, r_p} + (({r_rem, 1'b0} >= {1'b0, r_d}) ? 67'd1 : 67'd0);
            end
            L_FIN: begin
                if (w_big) begin
                    r_res <= r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    r_sat <= 1'b1;
                end else if (w_sum > 39'sd2147483647) begin
                    r_res <= 32'sh7fff_ffff;
                    r_sat <= 1'b1;
                end else if (w_sum < -39'sd2147483648) begin
                    r_res <= 32'sh8000_0000;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= w_sum[31:0];
                    r_sat <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_sat  = r_sat;

endmodule

[tb/breakpoint_table_interpolator_unit_checker.sv]
// checker for the breakpoint table interpolator: predicts and compares result words
`timescale 1ns / 100ps

module breakpoint_table_interpolator_unit_checker
    import btip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_mode,
    input  logic [3:0]         i_point_index,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_result_value,
    input  logic               i_below_range,
    input  logic               i_above_range,
    input  logic               i_saturated,
    output int                 o_pending,
    output int                 o_fail_count
);

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        logic signed [31:0] value;
        logic               below;
        logic               above;
        logic               sat;
    } t_lookup;

    logic signed [31:0] bp_x [TABLE_DEPTH];
    logic signed [31:0] bp_y [TABLE_DEPTH];
    logic [1:0]         kind_q;
    logic [4:0]         count_q;
    t_lookup            lookup_q [$];
    int                 fails;

    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // rounded y0 + dy*t/dx, ties away from zero, clipped to 32 bits
    function automatic t_lookup interpolate(input longint y0, input longint dy,
                                            input longint t, input longint dx);
        t_lookup         r;
        longint unsigned prod;
        longint unsigned quo;
        longint unsigned rem;
        longint          acc;
        logic            neg;
        prod = abs64(dy) * abs64(t);
        quo  = prod / longint'(dx);
        rem  = prod % longint'(dx);
        neg  = (dy < 0) != (t < 0);
        if (rem >= longint'(dx) - rem) quo++;
        if (quo > (64'd1 << 36)) begin
            acc = neg ? -(64'sd1 <<< 62) : (64'sd1 <<< 62);
        end else begin
            acc = neg ? y0 - longint'(quo) : y0 + longint'(quo);
        end
        r = '0;
        if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            r.sat = 1'b1;
        end
        if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.value = acc[31:0];
        return r;
    endfunction

    function automatic t_lookup evaluate_table(input logic signed [31:0] xq);
        t_lookup r;
        int      n;
        int      seg;
        longint  xv;
        longint  xa;
        longint  xb;
        longint  ya;
        longint  yb;
        r   = '0;
        n   = (count_q < 2) ? 2 : (count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_q);
        xv  = xq;
        seg = 0;
        for (int i = 1; i + 1 < n; i++) begin
            if (longint'(bp_x[i]) <= xv) seg++;
        end
        xa = bp_x[seg];
        xb = bp_x[seg + 1];
        ya = bp_y[seg];
        yb = bp_y[seg + 1];
        r.below = xv < longint'(bp_x[0]);
        r.above = xv > longint'(bp_x[n - 1]);
        if (kind_q == KIND_NEAREST) begin
            r.value = (abs64(xv - xa) < abs64(xv - xb)) ? ya[31:0] : yb[31:0];
        end else if (kind_q == KIND_CLAMP && r.below) begin
            r.value = bp_y[0];
        end else if (kind_q == KIND_CLAMP && r.above) begin
            r.value = bp_y[n - 1];
        end else if (xb <= xa) begin
            r.value = ya[31:0];
        end else begin
            t_lookup li;
            li      = interpolate(ya, yb - ya, xv - xa, xb - xa);
            r.value = li.value;
            r.sat   = li.sat;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            kind_q  = KIND_NEAREST;
            count_q = 5'd2;
            lookup_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KIND) kind_q = i_cfg_data[1:0];
                else count_q = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_LOAD) begin
                    bp_x[i_point_index] = i_x_value;
                    bp_y[i_point_index] = i_y_value;
                    lookup_q.push_back('0);
                end else begin
                    lookup_q.push_back(evaluate_table(i_x_value));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (lookup_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word: value %h", i_result_value);
                end else begin
                    want = lookup_q.pop_front();
                    if (want.value !== i_result_value || want.below !== i_below_range ||
                        want.above !== i_above_range || want.sat !== i_saturated) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected value %h below %b above %b sat %b, got %h %b %b %b",
                                     want.value, want.below, want.above, want.sat,
                                     i_result_value, i_below_range, i_above_range, i_saturated);
                    end
                end
            end
        end
        o_pending    <= lookup_q.size();
        o_fail_count <= fails;
    end

    initial begin
        fails        = 0;
        o_pending    = 0;
        o_fail_count = 0;
    end

endmodule

[tb/breakpoint_table_interpolator_unit_tb.sv]
// testbench top of the breakpoint table interpolator: stimulus and verdict
`timescale 1ns / 100ps

module breakpoint_table_interpolator_unit_tb;
    import btip_pkg::*;

    localparam logic       MODE_EVAL   = ~MODE_LOAD;
    localparam logic [1:0] KIND_EXTRAP = 2'd2;
    localparam logic [1:0] KIND_ALIAS  = 2'd3;   // acts as extrapolated
    localparam int         SLOTS       = 16;
    localparam int         SETTLE      = 150;    // beyond the slowest evaluate

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [4:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_mode;
    logic [3:0]         i_point_index;
    logic signed [31:0] i_x_value;
    logic signed [31:0] i_y_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_result_value;
    logic               o_below_range;
    logic               o_above_range;
    logic               o_saturated;
    int                 pending;
    int                 fail_count;

    // what the sender believes the table and count are, used to aim queries
    logic signed [31:0] sent_x [SLOTS];
    int                 cur_count;
    int                 words_sent;
    int                 burst_left;

    breakpoint_table_interpolator_unit uut (.*);

    breakpoint_table_interpolator_unit_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_mode, .i_point_index,
        .i_x_value, .i_y_value, .i_out_valid(o_out_valid), .i_out_stall,
        .i_result_value(o_result_value), .i_below_range(o_below_range),
        .i_above_range(o_above_range), .i_saturated(o_saturated),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver stall: free flow, light random stalls, or long stall runs
    int stall_style;
    int style_left;
    int stall_run;
    initial begin
        stall_style = 0;
        style_left  = 0;
        stall_run   = 0;
    end
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 2);
            style_left  = $urandom_range(50, 400);
        end
        style_left--;
        case (stall_style)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                if (stall_run == 0 && $urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 20);
                i_out_stall <= (stall_run > 0);
                if (stall_run > 0) stall_run--;
            end
        endcase
    end

    // one word on the input channel; bursts of random length, random gaps
    task automatic send_word(input logic m, input logic [3:0] idx,
                             input logic signed [31:0] xv, input logic signed [31:0] yv);
        int gap;
        i_mode        <= m;
        i_point_index <= idx;
        i_x_value     <= xv;
        i_y_value     <= yv;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        if (m == MODE_LOAD) sent_x[idx] = xv;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // sender holds off until every result word has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_COUNT) cur_count = (data < 2) ? 2 : (data > SLOTS) ? SLOTS : int'(data);
        @(posedge i_clk);
    endtask

    // fresh table: increasing x with a random step scale, sometimes broken order
    task automatic load_table;
        longint lim;
        longint xcur;
        int     scale;
        int     offs;
        int     k;
        logic signed [31:0] xs [SLOTS];
        logic signed [31:0] ys [SLOTS];
        scale = $urandom_range(0, 3);
        lim   = (scale == 0) ? 1 : (scale == 1) ? 256 : (scale == 2) ? 65536 : (64'd1 << 27);
        xcur  = longint'($urandom_range(0, 32'hFFFF_FFFF - 32'(15 * lim))) - 64'sd2147483648;
        for (int i = 0; i < SLOTS; i++) begin
            xs[i] = xcur[31:0];
            xcur += $urandom_range(1, 32'(lim));
            ys[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
        end
        if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(1, SLOTS - 1);
            xs[k] = ($urandom_range(0, 1) == 0) ? xs[k - 1] : $urandom;
        end
        offs = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            k = (i + offs) % SLOTS;
            send_word(MODE_LOAD, 4'(k), xs[k], ys[k]);
        end
    endtask

    function automatic logic signed [31:0] pick_query;
        int     k;
        longint a;
        longint b;
        k = $urandom_range(0, cur_count - 2);
        a = sent_x[k];
        b = sent_x[k + 1];
        case ($urandom_range(0, 8))
            0: return a[31:0];
            1: return b[31:0];
            2: return 32'(a + 1);
            3: return 32'(a - 1);
            4: return 32'((a + b) >>> 1);          // nearest tie when the sum is even
            5: return (b > a) ? 32'(a + longint'($urandom) % (b - a)) : a[31:0];
            6: return $urandom;
            7: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    initial begin
        int   kinds [4];
        logic [4:0] cdata;
        kinds       = '{KIND_NEAREST, KIND_CLAMP, KIND_EXTRAP, KIND_ALIAS};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_KIND;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_LOAD;
        i_point_index = '0;
        i_x_value   = '0;
        i_y_value   = '0;
        i_out_stall = 1'b0;
        cur_count   = 2;
        words_sent  = 0;
        burst_left  = 4;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: steep end segments so extrapolation clips at both ends
        for (int i = 0; i < SLOTS; i++) begin
            send_word(MODE_LOAD, 4'(i), 32'(-(64'sd1 <<< 30) + i * (64'sd1 <<< 27)),
                      (i == 0 || i == 14) ? 32'h8000_0000 :
                      (i == 1 || i == 15) ? 32'h7FFF_FFFF : $urandom);
        end
        drain();
        write_reg(CFG_COUNT, 5'd16);
        foreach (kinds[j]) begin
            drain();
            write_reg(CFG_KIND, 5'(kinds[j]));
            send_word(MODE_EVAL, 4'hF, 32'h8000_0000, 32'hFFFF_FFFF);
            send_word(MODE_EVAL, 4'h0, 32'h7FFF_FFFF, 32'h0);
            send_word(MODE_EVAL, 4'h5, 32'(-(64'sd1 <<< 30) + 3 * (64'sd1 <<< 26)), $urandom);
        end

        // random phases: registers at idle, then sometimes a table, then queries
        while (words_sent < 1000) begin
            drain();
            case ($urandom_range(0, 5))
                0: cdata = 5'd2;
                1: cdata = 5'd16;
                2: cdata = 5'($urandom_range(0, 1));
                3: cdata = 5'($urandom_range(17, 31));
                default: cdata = 5'($urandom_range(2, 16));
            endcase
            write_reg(CFG_COUNT, cdata);
            write_reg(CFG_KIND, 5'($urandom_range(0, 31)));
            if ($urandom_range(0, 2) != 0) load_table();
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 19) == 0)
                    send_word(MODE_LOAD, 4'($urandom), $urandom, $urandom);
                else
                    send_word(MODE_EVAL, 4'($urandom), pick_query(), $urandom);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
